// ===== sv/rdsrt_pkg.sv =====
// rdsrt_pkg: shared types and constants of the radiotext assembler
// used by rdsrt_store, rdsrt_ctrl, rdsrt_out and the top level
`timescale 1ns / 1ps

package rdsrt_pkg;

  // text geometry
  localparam int TEXT_LEN    = 64;
  localparam int COUNT_MAX   = 15;
  localparam int STORE_DEPTH = 64;
  localparam int LEN_2B      = 32;
  localparam int SIZE_2A     = (TEXT_LEN > STORE_DEPTH) ? STORE_DEPTH : TEXT_LEN;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int IDX_W  = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W  = $clog2(COUNT_MAX + 1);
  localparam int REQ_W  = 4;
  localparam int CMP_W  = (CNT_W > REQ_W) ? CNT_W : REQ_W;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

  // group type codes on the input
  localparam logic [1:0] GT_2A = 2'd0;
  localparam logic [1:0] GT_2B = 2'd1;

  // configuration register indexes
  localparam logic CFG_REQ_COUNT = 1'b0;
  localparam logic CFG_USE_AB    = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_2A   = 2'd1,
    KIND_2B   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_EMPTY      = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_COMPLETE   = 2'd2
  } fill_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_RD,
    S_WR_UPD,
    S_SCAN_RD,
    S_SCAN,
    S_DECIDE,
    S_EMIT,
    S_SINGLE
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [CHAR_W-1:0] chr;
  } entry_t;

  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } store_req_t;

  typedef struct packed {
    logic              push;
    fill_e             status;
    logic              text_valid;
    logic [CHAR_W-1:0] chr;
    logic              last;
  } out_push_t;

endpackage

// ===== sv/rds_radiotext_assembler.sv =====
// rds_radiotext_assembler: top level of the rds radiotext assembler
// instantiates rdsrt_ctrl, rdsrt_store and rdsrt_out; depends on rdsrt_pkg
`timescale 1ns / 1ps

// Usage
//   s_axis takes one checked rds group per beat; a beat with group_ok low is
//   dropped without any result. Each 2a/2b group updates the text store
//   (character plus repeat count per entry), the store is scanned up to a
//   carriage return, and m_axis returns either the confirmed text, one
//   character per beat with tlast on the final one, or a single beat with
//   text_valid low and tlast high. text_status rides on every result beat.
//   Configuration writes (cfg_we_i) are taken at any edge; write only while idle.
// Timing
//   one group is in work at a time. A 2a group takes four characters through
//   read-modify-write (one memory port, a read state and an update state per
//   character), a 2b group two; then a scan of up to 64 entries and a decide
//   state, then one result beat per cycle while m_axis is not stalled, up to 64.
//   The memory read port is shared by update, scan and emit.
// Reset and stall
//   reset clears the store valid bits at once, so the text reads empty with
//   no sweep. A stalled m_axis holds its beat; the emit sequence waits on it,
//   and s_axis_tready_o stays low until the group's last beat is registered.

module rds_radiotext_assembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // ab_flag, segment_addr[4:1], char_c_high[12:5], char_c_low[20:13],
  // char_d_high[28:21], char_d_low[36:29], zero pad
  input  logic [39:0] s_axis_tdata_i,
  // group_ok, group_type[2:1]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // text_status[1:0], text_char[9:2], zero pad
  output logic [15:0] m_axis_tdata_o,
  // text_valid
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  rdsrt_pkg::store_req_t store_req;
  rdsrt_pkg::entry_t     store_rsp;
  rdsrt_pkg::out_push_t  push;
  logic                  slot_free;
  logic [3:0][rdsrt_pkg::CHAR_W-1:0] chars;
  logic [1:0]            text_status;
  logic [rdsrt_pkg::CHAR_W-1:0] text_char;

  assign chars[0] = s_axis_tdata_i[12:5];
  assign chars[1] = s_axis_tdata_i[20:13];
  assign chars[2] = s_axis_tdata_i[28:21];
  assign chars[3] = s_axis_tdata_i[36:29];

  rdsrt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .group_ok_i     (s_axis_tuser_i[0]),
    .group_type_i   (s_axis_tuser_i[2:1]),
    .ab_flag_i      (s_axis_tdata_i[0]),
    .segment_addr_i (s_axis_tdata_i[4:1]),
    .chars_i        (chars),
    .store_req_o    (store_req),
    .store_rsp_i    (store_rsp),
    .push_o         (push),
    .slot_free_i    (slot_free)
  );

  rdsrt_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rsp_o  (store_rsp)
  );

  rdsrt_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .slot_free_o  (slot_free),
    .ready_i      (m_axis_tready_i),
    .valid_o      (m_axis_tvalid_o),
    .status_o     (text_status),
    .text_valid_o (m_axis_tuser_o),
    .chr_o        (text_char),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'd0, text_char, text_status};

`ifndef ASSERT_OFF
  // the read-modify-write sequence never reads and writes in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(store_req.rd_en && store_req.wr_en))
    else $error("store read and write in the same cycle");

  // no group is taken while a store update is under way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.wr_en |-> !s_axis_tready_o)
    else $error("input ready during store update");

  // a text character beat only comes from a complete text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (text_status == rdsrt_pkg::ST_COMPLETE))
    else $error("text character with status not complete");

  // a beat without a character is the only beat of its group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tlast_o && text_char == '0))
    else $error("empty result beat is not a lone last beat");
`endif

endmodule

// ===== sv/rdsrt_store.sv =====
// rdsrt_store: text store, one synchronous memory of character and repeat count
// with per-entry valid bits; depends on rdsrt_pkg
`timescale 1ns / 1ps

module rdsrt_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdsrt_pkg::store_req_t req_i,
  output rdsrt_pkg::entry_t   rsp_o
);

  rdsrt_pkg::entry_t                    mem [rdsrt_pkg::STORE_DEPTH];
  logic [rdsrt_pkg::STORE_DEPTH-1:0]    valid_q;
  rdsrt_pkg::entry_t                    rd_data_q;
  logic                                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // a cleared entry reads as zero character with zero count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rsp_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== sv/rdsrt_out.sv =====
// rdsrt_out: output register of the result stream
// depends on rdsrt_pkg
`timescale 1ns / 1ps

module rdsrt_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rdsrt_pkg::out_push_t        push_i,
  output logic                        slot_free_o,
  input  logic                        ready_i,
  output logic                        valid_o,
  output logic [1:0]                  status_o,
  output logic                        text_valid_o,
  output logic [rdsrt_pkg::CHAR_W-1:0] chr_o,
  output logic                        last_o
);

  logic                         valid_q;
  rdsrt_pkg::fill_e             status_q;
  logic                         text_valid_q;
  logic [rdsrt_pkg::CHAR_W-1:0] chr_q;
  logic                         last_q;

  assign slot_free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.push && slot_free_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push && slot_free_o) begin
      status_q     <= push_i.status;
      text_valid_q <= push_i.text_valid;
      chr_q        <= push_i.chr;
      last_q       <= push_i.last;
    end
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign text_valid_o = text_valid_q;
  assign chr_o        = chr_q;
  assign last_o       = last_q;

endmodule

// ===== sv/rdsrt_ctrl.sv =====
// rdsrt_ctrl: sequencer for character update, completeness scan and text emit
// drives rdsrt_store and rdsrt_out; depends on rdsrt_pkg
`timescale 1ns / 1ps

module rdsrt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rdsrt_pkg::REQ_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          group_ok_i,
  input  logic [1:0]                    group_type_i,
  input  logic                          ab_flag_i,
  input  logic [3:0]                    segment_addr_i,
  input  logic [3:0][rdsrt_pkg::CHAR_W-1:0] chars_i,
  output rdsrt_pkg::store_req_t         store_req_o,
  input  rdsrt_pkg::entry_t             store_rsp_i,
  output rdsrt_pkg::out_push_t          push_o,
  input  logic                          slot_free_i
);

  rdsrt_pkg::state_e state_q, state_d;
  rdsrt_pkg::kind_e  kind_q, kind_d;
  rdsrt_pkg::fill_e  fill_q, fill_d;
  logic              ab_seen_q, ab_seen_d;
  logic [rdsrt_pkg::REQ_W-1:0] req_cnt_q;
  logic              use_ab_q;
  logic [3:0]        addr_q, addr_d;
  logic [3:0][rdsrt_pkg::CHAR_W-1:0] chars_q, chars_d;
  logic [1:0]        k_q, k_d;
  logic [rdsrt_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [rdsrt_pkg::IDX_W-1:0] len_q, len_d;
  logic              found_q, found_d;
  logic              complete_q, complete_d;

  logic                         is_2a;
  logic [rdsrt_pkg::IDX_W-1:0]  size;
  logic [rdsrt_pkg::ADDR_W-1:0] pos;
  logic                         in_range;
  logic [1:0]                   sel;
  logic [rdsrt_pkg::CHAR_W-1:0] wchar;
  logic [rdsrt_pkg::CMP_W-1:0]  req;
  logic [rdsrt_pkg::CMP_W-1:0]  ent_cnt;
  logic                         hit;
  logic                         last_wr;
  logic [rdsrt_pkg::CNT_W-1:0]  new_cnt;
  logic                         do_clear;
  logic                         accept;

  assign is_2a = (kind_q == rdsrt_pkg::KIND_2A);
  assign size  = is_2a ? rdsrt_pkg::IDX_W'(rdsrt_pkg::SIZE_2A)
                       : rdsrt_pkg::IDX_W'(rdsrt_pkg::LEN_2B);
  assign pos   = is_2a ? rdsrt_pkg::ADDR_W'({addr_q, k_q})
                       : rdsrt_pkg::ADDR_W'({addr_q, k_q[0]});
  assign in_range = rdsrt_pkg::IDX_W'(pos) < size;
  // 2b groups carry their two characters in block 4
  assign sel     = is_2a ? k_q : {1'b1, k_q[0]};
  assign wchar   = chars_q[sel];
  assign last_wr = is_2a ? (k_q == 2'd3) : (k_q == 2'd1);

  // a required count of zero behaves as one
  assign req     = (req_cnt_q == '0) ? rdsrt_pkg::CMP_W'(1)
                                     : rdsrt_pkg::CMP_W'(req_cnt_q);
  assign ent_cnt = rdsrt_pkg::CMP_W'(store_rsp_i.cnt);
  assign hit     = ent_cnt >= req;
  assign in_ready_o = (state_q == rdsrt_pkg::S_IDLE);
  assign accept  = in_valid_i && in_ready_o;

  always_comb begin
    if (store_rsp_i.cnt == '0 || store_rsp_i.chr != wchar) begin
      new_cnt = rdsrt_pkg::CNT_W'(1);
    end else if (store_rsp_i.cnt < rdsrt_pkg::CNT_W'(rdsrt_pkg::COUNT_MAX)) begin
      new_cnt = store_rsp_i.cnt + rdsrt_pkg::CNT_W'(1);
    end else begin
      new_cnt = store_rsp_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rdsrt_pkg::S_IDLE;
      kind_q     <= rdsrt_pkg::KIND_NONE;
      fill_q     <= rdsrt_pkg::ST_EMPTY;
      ab_seen_q  <= 1'b0;
      req_cnt_q  <= rdsrt_pkg::REQ_W'(1);
      use_ab_q   <= 1'b1;
      k_q        <= '0;
      idx_q      <= '0;
      len_q      <= '0;
      found_q    <= 1'b0;
      complete_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      fill_q     <= fill_d;
      ab_seen_q  <= ab_seen_d;
      k_q        <= k_d;
      idx_q      <= idx_d;
      len_q      <= len_d;
      found_q    <= found_d;
      complete_q <= complete_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == rdsrt_pkg::CFG_REQ_COUNT) begin
          req_cnt_q <= cfg_wdata_i;
        end else begin
          use_ab_q <= cfg_wdata_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    chars_q <= chars_d;
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    fill_d     = fill_q;
    ab_seen_d  = ab_seen_q;
    addr_d     = addr_q;
    chars_d    = chars_q;
    k_d        = k_q;
    idx_d      = idx_q;
    len_d      = len_q;
    found_d    = found_q;
    complete_d = complete_q;
    do_clear   = 1'b0;

    store_req_o         = '0;
    store_req_o.rd_addr = pos;
    store_req_o.wr_addr = pos;
    store_req_o.wr_data = '{cnt: new_cnt, chr: wchar};

    push_o            = '0;
    push_o.status     = fill_q;
    push_o.text_valid = 1'b0;
    push_o.chr        = '0;
    push_o.last       = 1'b1;

    unique case (state_q)
      rdsrt_pkg::S_IDLE: begin
        if (accept && group_ok_i) begin
          addr_d    = segment_addr_i;
          chars_d   = chars_i;
          k_d       = '0;
          ab_seen_d = ab_flag_i;
          if (ab_flag_i != ab_seen_q && use_ab_q) begin
            do_clear = 1'b1;
          end
          case (group_type_i)
            rdsrt_pkg::GT_2A: begin
              kind_d  = rdsrt_pkg::KIND_2A;
              state_d = rdsrt_pkg::S_WR_RD;
              if (kind_q != rdsrt_pkg::KIND_2A) begin
                do_clear = 1'b1;
              end
            end
            rdsrt_pkg::GT_2B: begin
              kind_d  = rdsrt_pkg::KIND_2B;
              state_d = rdsrt_pkg::S_WR_RD;
              if (kind_q != rdsrt_pkg::KIND_2B) begin
                do_clear = 1'b1;
              end
            end
            default: begin
              kind_d  = rdsrt_pkg::KIND_NONE;
              state_d = rdsrt_pkg::S_SINGLE;
            end
          endcase
          if (do_clear || (group_type_i != rdsrt_pkg::GT_2A &&
                           group_type_i != rdsrt_pkg::GT_2B)) begin
            fill_d = rdsrt_pkg::ST_EMPTY;
          end
        end
      end
      rdsrt_pkg::S_WR_RD: begin
        store_req_o.rd_en = 1'b1;
        state_d = rdsrt_pkg::S_WR_UPD;
      end
      rdsrt_pkg::S_WR_UPD: begin
        if (in_range) begin
          store_req_o.wr_en = 1'b1;
          if (fill_q != rdsrt_pkg::ST_COMPLETE) begin
            fill_d = rdsrt_pkg::ST_INCOMPLETE;
          end
        end
        if (last_wr) begin
          state_d = rdsrt_pkg::S_SCAN_RD;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = rdsrt_pkg::S_WR_RD;
        end
      end
      rdsrt_pkg::S_SCAN_RD: begin
        store_req_o.rd_en   = 1'b1;
        store_req_o.rd_addr = '0;
        idx_d      = '0;
        found_d    = 1'b0;
        complete_d = 1'b1;
        state_d    = rdsrt_pkg::S_SCAN;
      end
      rdsrt_pkg::S_SCAN: begin
        // entry idx_q is on the read port; next read goes out in the same cycle
        found_d = found_q | hit;
        if (store_rsp_i.chr == rdsrt_pkg::CHAR_CR) begin
          len_d   = idx_q;
          state_d = rdsrt_pkg::S_DECIDE;
        end else begin
          if (!hit) begin
            complete_d = 1'b0;
          end
          if (idx_q == size - rdsrt_pkg::IDX_W'(1)) begin
            len_d   = size;
            state_d = rdsrt_pkg::S_DECIDE;
          end else begin
            store_req_o.rd_en   = 1'b1;
            store_req_o.rd_addr = rdsrt_pkg::ADDR_W'(idx_q + rdsrt_pkg::IDX_W'(1));
            idx_d = idx_q + rdsrt_pkg::IDX_W'(1);
          end
        end
      end
      rdsrt_pkg::S_DECIDE: begin
        store_req_o.rd_en   = 1'b1;
        store_req_o.rd_addr = '0;
        idx_d = '0;
        if (found_q && complete_q) begin
          fill_d  = rdsrt_pkg::ST_COMPLETE;
          state_d = (len_q == '0) ? rdsrt_pkg::S_SINGLE : rdsrt_pkg::S_EMIT;
        end else begin
          state_d = rdsrt_pkg::S_SINGLE;
        end
      end
      rdsrt_pkg::S_EMIT: begin
        push_o.text_valid = 1'b1;
        push_o.chr        = store_rsp_i.chr;
        push_o.last       = (idx_q == len_q - rdsrt_pkg::IDX_W'(1));
        if (slot_free_i) begin
          push_o.push = 1'b1;
          if (push_o.last) begin
            state_d = rdsrt_pkg::S_IDLE;
          end else begin
            store_req_o.rd_en   = 1'b1;
            store_req_o.rd_addr = rdsrt_pkg::ADDR_W'(idx_q + rdsrt_pkg::IDX_W'(1));
            idx_d = idx_q + rdsrt_pkg::IDX_W'(1);
          end
        end
      end
      rdsrt_pkg::S_SINGLE: begin
        if (slot_free_i) begin
          push_o.push = 1'b1;
          state_d     = rdsrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rdsrt_pkg::S_IDLE;
      end
    endcase

    store_req_o.clear = do_clear;
  end

endmodule

// ===== verif/rds_radiotext_checker.sv =====
// rds_radiotext_checker: watches the config port and both streams of the radiotext
// assembler, predicts every result beat of each accepted group and compares them in order
// depends on rdsrt_pkg for the kind, status and config codes
`timescale 1ns / 1ps

module rds_radiotext_checker
  import rdsrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // ab_flag, segment_addr[4:1], char_c_high[12:5], char_c_low[20:13],
  // char_d_high[28:21], char_d_low[36:29], zero pad
  input  logic [39:0] s_axis_tdata_i,
  // group_ok, group_type[2:1]
  input  logic [2:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // text_status[1:0], text_char[9:2], zero pad
  input  logic [15:0] m_axis_tdata_i,
  // text_valid
  input  logic        m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    fill_e       status;
    logic        valid;
    logic [7:0]  chr;
    logic        last;
  } rt_beat_t;

  logic [7:0]  rt_chars  [STORE_DEPTH];
  logic [3:0]  rt_counts [STORE_DEPTH];
  logic        ab_last;
  kind_e       cur_kind;
  fill_e       cur_fill;
  logic [3:0]  cfg_req;
  logic        cfg_use_ab;
  rt_beat_t    owed_q [$];
  int unsigned fails;

  function automatic int text_span();
    return (cur_kind == KIND_2B) ? LEN_2B : SIZE_2A;
  endfunction

  function automatic void wipe_text();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      rt_chars[i]  = '0;
      rt_counts[i] = '0;
    end
    cur_fill = ST_EMPTY;
  endfunction

  function automatic void pick_kind(kind_e k);
    if (cur_kind != k) begin
      cur_kind = k;
      wipe_text();
    end
  endfunction

  // queue one expected beat behind the ones already owed
  function automatic void owe_beat(rt_beat_t b);
    owed_q = {owed_q, b};
  endfunction

  // repeat counter restarts on a new character, saturates otherwise
  function automatic void write_entry(int pos, logic [7:0] c);
    if (pos >= text_span()) return;
    if (rt_counts[pos] == 0 || rt_chars[pos] != c) rt_counts[pos] = 4'd1;
    else if (rt_counts[pos] < COUNT_MAX) rt_counts[pos] = rt_counts[pos] + 4'd1;
    rt_chars[pos] = c;
    if (cur_fill != ST_COMPLETE) cur_fill = ST_INCOMPLETE;
  endfunction

  task automatic predict_text(input logic [39:0] d, input logic [2:0] u);
    logic [1:0] gtype;
    logic [3:0] seg;
    logic       ab;
    int         span;
    int         req;
    int         emit_len;
    bit         found;
    bit         whole;
    rt_beat_t   beat;
    gtype = u[2:1];
    ab    = d[0];
    seg   = d[4:1];
    if (ab != ab_last) begin
      ab_last = ab;
      if (cfg_use_ab) wipe_text();
    end
    if (gtype == GT_2A) begin
      pick_kind(KIND_2A);
      for (int k = 0; k < 4; k++) write_entry(4 * seg + k, d[5 + 8 * k +: 8]);
    end else if (gtype == GT_2B) begin
      pick_kind(KIND_2B);
      write_entry(2 * seg, d[28:21]);
      write_entry(2 * seg + 1, d[36:29]);
    end else begin
      cur_kind = KIND_NONE;
      cur_fill = ST_EMPTY;
      beat = '{status: ST_EMPTY, valid: 1'b0, chr: 8'h00, last: 1'b1};
      owe_beat(beat);
      return;
    end
    span  = text_span();
    req   = (cfg_req == 4'd0) ? 1 : int'(cfg_req);
    found = 1'b0;
    whole = 1'b1;
    // a carriage return ends the text; it may itself be the confirmed entry
    for (int i = 0; i < span; i++) begin
      if (rt_counts[i] >= req) found = 1'b1;
      if (rt_chars[i] == CHAR_CR) break;
      if (rt_counts[i] < req) whole = 1'b0;
    end
    emit_len = 0;
    if (found && whole) begin
      cur_fill = ST_COMPLETE;
      while (emit_len < span && rt_chars[emit_len] != CHAR_CR &&
             rt_counts[emit_len] >= req)
        emit_len++;
    end
    if (emit_len == 0) begin
      beat = '{status: cur_fill, valid: 1'b0, chr: 8'h00, last: 1'b1};
      owe_beat(beat);
    end else begin
      for (int i = 0; i < emit_len; i++) begin
        beat = '{status: cur_fill, valid: 1'b1, chr: rt_chars[i],
                 last: (i == emit_len - 1)};
        owe_beat(beat);
      end
    end
  endtask

  task automatic check_beat();
    rt_beat_t exp;
    if (owed_q.size() == 0) begin
      if (fails < 10)
        $display("%0t: unexpected result beat, status %0d valid %0b char %02h last %0b",
                 $time, m_axis_tdata_i[1:0], m_axis_tuser_i, m_axis_tdata_i[9:2],
                 m_axis_tlast_i);
      fails++;
      return;
    end
    exp = owed_q.pop_front();
    if (m_axis_tdata_i[1:0] !== exp.status || m_axis_tuser_i !== exp.valid ||
        m_axis_tdata_i[9:2] !== exp.chr || m_axis_tlast_i !== exp.last) begin
      if (fails < 10)
        $display("%0t: beat mismatch, expected status %0d valid %0b char %02h last %0b, %s",
                 $time, exp.status, exp.valid, exp.chr, exp.last,
                 $sformatf("got status %0d valid %0b char %02h last %0b",
                           m_axis_tdata_i[1:0], m_axis_tuser_i, m_axis_tdata_i[9:2],
                           m_axis_tlast_i));
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_text();
      ab_last    = 1'b0;
      cur_kind   = KIND_NONE;
      cfg_req    = 4'd1;
      cfg_use_ab = 1'b1;
      owed_q.delete();
      fails      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_REQ_COUNT) cfg_req = cfg_wdata_i;
        else cfg_use_ab = cfg_wdata_i[0];
      end
      if (m_axis_tvalid_i && m_axis_tready_i) check_beat();
      if (s_axis_tvalid_i && s_axis_tready_i && s_axis_tuser_i[0])
        predict_text(s_axis_tdata_i, s_axis_tuser_i);
      fail_count_o <= fails;
      pending_o    <= owed_q.size();
    end
  end

endmodule

// ===== verif/rds_radiotext_assembler_test.sv =====
// rds_radiotext_assembler_test: drives groups and config writes into the assembler,
// with rds_radiotext_checker beside it; depends on rdsrt_pkg and the assembler rtl
`timescale 1ns / 1ps

module rds_radiotext_assembler_test;
  import rdsrt_pkg::*;

  localparam logic [1:0] GT_OTHER = 2'd2;
  localparam logic [1:0] GT_SPARE = 2'd3;
  localparam int         PHASE_GROUPS = 42;
  localparam int         SETTLE_CYCLES = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_REQ_COUNT;
  logic [3:0]  cfg_wdata_i = 4'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int unsigned fail_count;
  int unsigned pending;
  int          tx_idle = 16;
  int          rx_idle = 47;
  int          groups_sent = 0;

  // current broadcast text that the well-formed groups repeat
  logic [7:0]  msg_text [64];
  logic [1:0]  msg_type;
  logic        msg_ab = 1'b0;
  int          msg_segs;
  int          msg_seg;

  rds_radiotext_assembler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  rds_radiotext_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= rx_idle);
  end

  task automatic send_group(input logic ok, input logic [1:0] gtype, input logic ab,
                            input logic [3:0] seg, input logic [7:0] c0,
                            input logic [7:0] c1, input logic [7:0] c2,
                            input logic [7:0] c3);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i  <= {3'b000, c3, c2, c1, c0, seg, ab};
    s_axis_tuser_i  <= {gtype, ok};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (ok) groups_sent++;
  endtask

  // only between phases: every owed beat is back and the block has gone quiet
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [3:0] req, input logic use_ab);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_REQ_COUNT;
    cfg_wdata_i <= req;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_USE_AB;
    cfg_wdata_i <= {3'b000, use_ab};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly short texts ended by a carriage return, now and then a full one without
  task automatic new_message();
    int per;
    int cap;
    int len;
    logic [7:0] c;
    msg_type = $urandom_range(1) ? GT_2B : GT_2A;
    if ($urandom_range(3) == 0) msg_ab = ~msg_ab;
    per = (msg_type == GT_2A) ? 4 : 2;
    cap = (msg_type == GT_2A) ? 64 : 32;
    len = ($urandom_range(9) == 0) ? cap : $urandom_range(12, 1);
    for (int i = 0; i < 64; i++) begin
      c = 8'($urandom_range(255));
      if (c == CHAR_CR) c = 8'h20;
      msg_text[i] = (i < len) ? c : 8'h20;
    end
    if (len < cap) msg_text[len - 1] = CHAR_CR;
    msg_segs = (len + per - 1) / per;
    msg_seg  = 0;
  endtask

  task automatic send_segment(input bit corrupt);
    int base;
    logic [7:0] c [4];
    if (msg_type == GT_2A) begin
      base = 4 * msg_seg;
      for (int k = 0; k < 4; k++) c[k] = msg_text[base + k];
      if (corrupt) c[$urandom_range(3)] = 8'($urandom_range(255));
    end else begin
      base = 2 * msg_seg;
      c[0] = 8'($urandom_range(255));
      c[1] = 8'($urandom_range(255));
      c[2] = msg_text[base];
      c[3] = msg_text[base + 1];
      if (corrupt) c[$urandom_range(3, 2)] = 8'($urandom_range(255));
    end
    send_group(1'b1, msg_type, msg_ab, 4'(msg_seg), c[0], c[1], c[2], c[3]);
    msg_seg = (msg_seg + 1) % msg_segs;
  endtask

  task automatic random_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      new_message();
      send_segment(1'b0);
    end else if (roll < 74) begin
      send_segment(1'b0);
    end else if (roll < 80) begin
      send_segment(1'b1);
    end else if (roll < 86) begin
      send_group(1'b1, $urandom_range(1) ? GT_OTHER : GT_SPARE, msg_ab,
                 4'($urandom_range(15)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    end else begin
      // dropped groups and fully random ones
      send_group(roll < 92 ? 1'b0 : 1'b1, 2'($urandom_range(3)), 1'($urandom_range(1)),
                 4'($urandom_range(15)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [3:0] req_tab [7];
    logic       ab_tab  [7];
    int         start;
    req_tab = '{4'd1, 4'd15, 4'd2, 4'd1, 4'd3, 4'd15, 4'd1};
    ab_tab  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    set_config(req_tab[0], ab_tab[0]);

    // directed groups
    send_group(1'b0, GT_SPARE, 1'b1, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_group(1'b1, GT_OTHER, 1'b0, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_group(1'b1, GT_2A, 1'b0, 4'h0, "A", "B", CHAR_CR, " ");
    send_group(1'b1, GT_2A, 1'b0, 4'h1, 8'hFF, 8'h00, 8'h80, 8'h7F);
    // carriage return first: complete but nothing to emit
    send_group(1'b1, GT_2A, 1'b0, 4'h0, CHAR_CR, "x", "y", "z");
    send_group(1'b1, GT_2A, 1'b1, 4'hF, "p", "q", "r", "s");
    send_group(1'b1, GT_2B, 1'b1, 4'h0, 8'hAA, 8'h55, "h", "i");
    send_group(1'b1, GT_2B, 1'b1, 4'h1, 8'h00, 8'hFF, CHAR_CR, " ");
    // full 64-character text with no carriage return
    for (int s = 0; s < 16; s++)
      send_group(1'b1, GT_2A, 1'b0, 4'(s), 8'(8'h30 + 4 * s), 8'(8'h31 + 4 * s),
                 8'(8'h32 + 4 * s), 8'(8'h33 + 4 * s));

    for (int p = 1; p < 7; p++) begin
      settle();
      if (p >= 5) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (p >= 3) begin
        tx_idle = 47;
        rx_idle = 16;
      end
      set_config(req_tab[p], ab_tab[p]);
      new_message();
      start = groups_sent;
      while (groups_sent - start < PHASE_GROUPS) random_item();
    end

    settle();
    if (fail_count == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
